// ===== design/fade_envelope_generator_unit_assert.svh =====
// Assertion macros shared by the fade envelope generator modules.
// Each macro takes a label, the clock, the reset and the checked expressions.
`ifndef FADE_ENVELOPE_GENERATOR_UNIT_ASSERT_SVH
`define FADE_ENVELOPE_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define FEG_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FEG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/feg_pkg.sv =====
// Package for the fade envelope generator: word types, phase codes,
// datapath operation codes, register indexes and fixed-point constants.
`default_nettype none

package feg_pkg;

   localparam int TIME_W   = 32;
   localparam int WEIGHT_W = 17;
   localparam int PHASE_W  = 3;
   localparam int CSR_IDX_W = 2;

   // 0.01 s in Q16.16 and 1.0 in Q1.16
   localparam logic [TIME_W-1:0]   THR = 32'd655;
   localparam logic [WEIGHT_W-1:0] ONE = 17'h10000;

   // quotient bits produced by the serial divider
   localparam int QBITS = 17;
   localparam int CNT_W = 5;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QBITS - 1);

   localparam logic [CSR_IDX_W-1:0] CSR_START_TIME    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_IN_TIME  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TIME     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_OUT_TIME = 2'd3;

   typedef enum logic [PHASE_W-1:0] {
      PH_WAIT     = 3'd0,
      PH_FADE_IN  = 3'd1,
      PH_HOLD     = 3'd2,
      PH_FADE_OUT = 3'd3,
      PH_DONE     = 3'd4
   } phase_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_REQUEST,
      OP_ABS_START,
      OP_ABS_FADE_IN,
      OP_ABS_HOLD,
      OP_ABS_FADE_OUT,
      OP_ABS_IN_APPLY,
      OP_ABS_OUT_APPLY,
      OP_STEP_ADD,
      OP_STEP_WAIT_CHK,
      OP_STEP_IN_APPLY,
      OP_STEP_HOLD_CHK,
      OP_STEP_OUT_APPLY,
      OP_DIV_START,
      OP_RESULT
   } op_type;

   typedef struct packed {
      logic              req_type;
      logic [TIME_W-1:0] time_now;
      logic [TIME_W-1:0] time_step;
      logic [TIME_W-1:0] forced_fade_time;
   } req_word_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] weight;
      logic [PHASE_W-1:0]  phase;
   } rsp_word_type;

   typedef struct packed {
      logic      req_type;
      logic      forced_mode;
      phase_type phase;
      logic      sub_neg;
      logic      hold_short;
      logic      div_done;
   } status_type;

endpackage

`default_nettype wire

// ===== design/feg_divider.sv =====
// Serial restoring divider: floor(num * 65536 / den) clamped to 1.0 (Q1.16).
// One quotient bit per cycle; depends on feg_pkg.
`default_nettype none
`include "fade_envelope_generator_unit_assert.svh"

module feg_divider
   import feg_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [TIME_W-1:0]   num,
   input  wire logic [TIME_W-1:0]   den,
   output logic                     done,
   output logic [WEIGHT_W-1:0]      quot
);

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_RUN,
      DV_FIN
   } dv_state_type;

   dv_state_type          state_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [TIME_W-1:0]     rem_ff;
   logic [TIME_W-1:0]     den_ff;
   logic                  nbit_ff;
   logic                  sat_ff;
   logic [QBITS-1:0]      q_ff;

   logic [TIME_W:0]       shifted;
   logic [TIME_W+1:0]     trial;
   logic                  fits;
   logic                  sat_chk;

   always_comb begin
      shifted = {rem_ff, nbit_ff};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
      fits    = !trial[TIME_W+1];
      // quotient reaches 2^17 or more, or division by zero
      sat_chk = (den == '0) || ({1'b0, num} >= {den, 1'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            DV_IDLE: begin
               if (start) begin
                  den_ff <= den;
                  q_ff   <= '0;
                  if (sat_chk) begin
                     sat_ff   <= 1'b1;
                     state_ff <= DV_FIN;
                  end else begin
                     sat_ff   <= 1'b0;
                     rem_ff   <= {1'b0, num[TIME_W-1:1]};
                     nbit_ff  <= num[0];
                     cnt_ff   <= CNT_LAST;
                     state_ff <= DV_RUN;
                  end
               end
            end
            DV_RUN: begin
               nbit_ff <= 1'b0;
               rem_ff  <= fits ? trial[TIME_W-1:0] : shifted[TIME_W-1:0];
               q_ff    <= {q_ff[QBITS-2:0], fits};
               if (cnt_ff == '0) begin
                  state_ff <= DV_FIN;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            DV_FIN: begin
               q_ff     <= (sat_ff || q_ff > ONE) ? ONE : q_ff;
               done_ff  <= 1'b1;
               state_ff <= DV_IDLE;
            end
            default: begin
               state_ff <= DV_IDLE;
            end
         endcase
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

   `FEG_ASSERT_IMPLY(a_start_idle, clock, reset, start, state_ff == DV_IDLE, "divider started while busy")
   `FEG_ASSERT_NEXT(a_done_pulse, clock, reset, done_ff, !done_ff, "divider done longer than one cycle")
   `FEG_ASSERT_IMPLY(a_quot_range, clock, reset, done_ff, q_ff <= ONE, "quotient above one")

endmodule

`default_nettype wire

// ===== design/feg_datapath.sv =====
// Datapath: configuration registers, envelope state, item and result words,
// the subtract/compare unit and the shared divider. Depends on feg_pkg, feg_divider.
`default_nettype none
`include "fade_envelope_generator_unit_assert.svh"

module feg_datapath
   import feg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [TIME_W-1:0]     csr_wdata,
   input  wire req_word_type          req_data,
   output rsp_word_type               rsp_data,
   input  wire op_type                op,
   output status_type                 sts
);

   logic [TIME_W-1:0]   start_time_ff;
   logic [TIME_W-1:0]   fade_in_time_ff;
   logic [TIME_W-1:0]   hold_time_ff;
   logic [TIME_W-1:0]   fade_out_time_ff;

   phase_type           phase_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic [TIME_W-1:0]   elapsed_ff;
   logic                forced_mode_ff;
   logic [TIME_W-1:0]   forced_length_ff;

   req_word_type        item_ff;
   logic [TIME_W-1:0]   fo_ff;
   logic [TIME_W-1:0]   work_ff;
   rsp_word_type        rsp_ff;

   logic [TIME_W-1:0]   sub_a;
   logic [TIME_W-1:0]   sub_b;
   logic [TIME_W:0]     diff;
   logic                neg;
   logic                hold_short;
   logic [TIME_W:0]     step_sum;
   logic [TIME_W-1:0]   elapsed_sat;
   logic [WEIGHT_W:0]   w_up;
   logic                div_done;
   logic [WEIGHT_W-1:0] quot;
   logic [TIME_W-1:0]   div_num;
   logic [TIME_W-1:0]   div_den;

   always_comb begin
      sub_a = work_ff;
      sub_b = fo_ff;
      case (op)
         OP_ABS_START: begin
            sub_a = item_ff.time_now;
            sub_b = start_time_ff;
         end
         OP_ABS_FADE_IN:  sub_b = fade_in_time_ff;
         OP_ABS_HOLD:     sub_b = hold_time_ff;
         default:         sub_b = fo_ff;
      endcase
      diff        = {1'b0, sub_a} - {1'b0, sub_b};
      neg         = diff[TIME_W];
      hold_short  = hold_time_ff < THR;
      step_sum    = {1'b0, elapsed_ff} + {1'b0, item_ff.time_step};
      elapsed_sat = step_sum[TIME_W] ? '1 : step_sum[TIME_W-1:0];
      w_up        = {1'b0, weight_ff} + {1'b0, quot};
      div_num     = forced_mode_ff ? item_ff.time_step : elapsed_ff;
      div_den     = (phase_ff == PH_FADE_IN) ? fade_in_time_ff : fo_ff;
   end

   feg_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (op == OP_DIV_START),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         start_time_ff    <= '0;
         fade_in_time_ff  <= '0;
         hold_time_ff     <= '0;
         fade_out_time_ff <= '0;
         phase_ff         <= PH_WAIT;
         weight_ff        <= '0;
         elapsed_ff       <= '0;
         forced_mode_ff   <= 1'b0;
         forced_length_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_START_TIME:    start_time_ff    <= csr_wdata;
               CSR_FADE_IN_TIME:  fade_in_time_ff  <= csr_wdata;
               CSR_HOLD_TIME:     hold_time_ff     <= csr_wdata;
               CSR_FADE_OUT_TIME: fade_out_time_ff <= csr_wdata;
               default: ;
            endcase
         end
         case (op)
            OP_REQUEST: begin
               forced_mode_ff   <= 1'b1;
               forced_length_ff <= (item_ff.forced_fade_time > THR) ?
                                   item_ff.forced_fade_time : '0;
               elapsed_ff       <= '0;
               case (phase_ff) inside
                  PH_WAIT, PH_DONE:                 phase_ff <= PH_DONE;
                  PH_FADE_IN, PH_HOLD, PH_FADE_OUT: phase_ff <= PH_FADE_OUT;
                  default: ;
               endcase
            end
            OP_ABS_START: begin
               if (neg) begin
                  elapsed_ff <= item_ff.time_now;
                  weight_ff  <= '0;
                  phase_ff   <= PH_WAIT;
               end
            end
            OP_ABS_FADE_IN: begin
               if (neg) begin
                  elapsed_ff <= work_ff;
                  phase_ff   <= PH_FADE_IN;
               end
            end
            OP_ABS_HOLD: begin
               if (neg || hold_short) begin
                  elapsed_ff <= work_ff;
                  weight_ff  <= ONE;
                  phase_ff   <= PH_HOLD;
               end
            end
            OP_ABS_FADE_OUT: begin
               if (neg) begin
                  elapsed_ff <= work_ff;
                  phase_ff   <= PH_FADE_OUT;
               end else begin
                  elapsed_ff <= '0;
                  weight_ff  <= '0;
                  phase_ff   <= PH_DONE;
               end
            end
            OP_ABS_IN_APPLY:  weight_ff <= quot;
            OP_ABS_OUT_APPLY: weight_ff <= ONE - quot;
            OP_STEP_ADD:      elapsed_ff <= elapsed_sat;
            OP_STEP_WAIT_CHK: begin
               if (elapsed_ff > start_time_ff) begin
                  elapsed_ff <= '0;
                  weight_ff  <= '0;
                  phase_ff   <= PH_FADE_IN;
               end
            end
            OP_STEP_IN_APPLY: begin
               if (elapsed_ff > fade_in_time_ff || w_up >= {1'b0, ONE}) begin
                  weight_ff  <= ONE;
                  elapsed_ff <= '0;
                  phase_ff   <= PH_HOLD;
               end else begin
                  weight_ff <= w_up[WEIGHT_W-1:0];
               end
            end
            OP_STEP_HOLD_CHK: begin
               if (elapsed_ff > hold_time_ff && !hold_short) begin
                  elapsed_ff <= '0;
                  weight_ff  <= ONE;
                  phase_ff   <= PH_FADE_OUT;
               end
            end
            OP_STEP_OUT_APPLY: begin
               if (elapsed_ff > fo_ff || weight_ff <= quot) begin
                  elapsed_ff <= '0;
                  weight_ff  <= '0;
                  phase_ff   <= PH_DONE;
               end else begin
                  weight_ff <= weight_ff - quot;
               end
            end
            default: ;
         endcase
      end
   end

   // item word, effective fade-out length, placement remainder, result word
   always_ff @(posedge clock) begin
      case (op)
         OP_LOAD: begin
            item_ff <= req_data;
            fo_ff   <= (forced_length_ff > THR) ? forced_length_ff : fade_out_time_ff;
         end
         OP_ABS_START, OP_ABS_FADE_IN, OP_ABS_HOLD, OP_ABS_FADE_OUT: begin
            work_ff <= diff[TIME_W-1:0];
         end
         OP_RESULT: begin
            rsp_ff.weight <= weight_ff;
            rsp_ff.phase  <= phase_ff;
         end
         default: ;
      endcase
   end

   assign rsp_data        = rsp_ff;
   assign sts.req_type    = item_ff.req_type;
   assign sts.forced_mode = forced_mode_ff;
   assign sts.phase       = phase_ff;
   assign sts.sub_neg     = neg;
   assign sts.hold_short  = hold_short;
   assign sts.div_done    = div_done;

   `FEG_ASSERT_IMPLY(a_weight_range, clock, reset, 1'b1, weight_ff <= ONE, "weight above one")

endmodule

`default_nettype wire

// ===== design/feg_controller.sv =====
// Sequencer for the fade envelope generator: handshakes and datapath operations.
// Depends on feg_pkg.
`default_nettype none
`include "fade_envelope_generator_unit_assert.svh"

module feg_controller
   import feg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   input  wire status_type  sts,
   output op_type           op
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ABS_S,
      ST_ABS_FI,
      ST_ABS_H,
      ST_ABS_FO,
      ST_STEP_ADD,
      ST_STEP_CHK,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_APPLY,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op       = OP_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (sts.req_type) begin
               op       = OP_REQUEST;
               state_in = ST_DONE;
            end else if (!sts.forced_mode) begin
               state_in = ST_ABS_S;
            end else begin
               case (sts.phase) inside
                  PH_WAIT, PH_FADE_IN, PH_HOLD, PH_FADE_OUT: state_in = ST_STEP_ADD;
                  default:                                   state_in = ST_DONE;
               endcase
            end
         end
         ST_ABS_S: begin
            op       = OP_ABS_START;
            state_in = sts.sub_neg ? ST_DONE : ST_ABS_FI;
         end
         ST_ABS_FI: begin
            op       = OP_ABS_FADE_IN;
            state_in = sts.sub_neg ? ST_DIV_START : ST_ABS_H;
         end
         ST_ABS_H: begin
            op       = OP_ABS_HOLD;
            state_in = (sts.sub_neg || sts.hold_short) ? ST_DONE : ST_ABS_FO;
         end
         ST_ABS_FO: begin
            op       = OP_ABS_FADE_OUT;
            state_in = sts.sub_neg ? ST_DIV_START : ST_DONE;
         end
         ST_STEP_ADD: begin
            op       = OP_STEP_ADD;
            state_in = ST_STEP_CHK;
         end
         ST_STEP_CHK: begin
            case (sts.phase) inside
               PH_WAIT: begin
                  op       = OP_STEP_WAIT_CHK;
                  state_in = ST_DONE;
               end
               PH_HOLD: begin
                  op       = OP_STEP_HOLD_CHK;
                  state_in = ST_DONE;
               end
               PH_FADE_IN, PH_FADE_OUT: state_in = ST_DIV_START;
               default:                 state_in = ST_DONE;
            endcase
         end
         ST_DIV_START: begin
            op       = OP_DIV_START;
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (sts.div_done) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (sts.forced_mode) begin
               op = (sts.phase == PH_FADE_IN) ? OP_STEP_IN_APPLY : OP_STEP_OUT_APPLY;
            end else begin
               op = (sts.phase == PH_FADE_IN) ? OP_ABS_IN_APPLY : OP_ABS_OUT_APPLY;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // load the output word only once the previous one is gone
            if (!rsp_valid_ff || !rsp_stall) begin
               op       = OP_RESULT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = (op == OP_RESULT) || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `FEG_ASSERT_IMPLY(a_no_overwrite, clock, reset, op == OP_RESULT, !rsp_valid_ff || !rsp_stall, "waiting word overwritten")

endmodule

`default_nettype wire

// ===== design/fade_envelope_generator_unit.sv =====
// Fade envelope generator, top level: controller, datapath and configuration port.
// Depends on feg_pkg, feg_controller, feg_datapath.
//
// Each accepted word yields one result word carrying the weight (Q1.16) and the
// phase after the word is applied. One word is processed at a time. Forced
// fade-out requests, absolute ticks and stepped ticks take their own paths
// through the controller, and a tick that needs the weight quotient (fade-in
// or fade-out, absolute or stepped) waits for the serial divider, which
// produces one of 17 quotient bits per cycle. A stalled receiver holds the
// result word in the output register. A new word is taken while the previous
// result still waits in the output register. The user must write configuration
// registers only while no word is in flight; the block itself does not
// enforce this.
`default_nettype none

module fade_envelope_generator_unit
   import feg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_word_type          req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_word_type               rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [TIME_W-1:0]     csr_wdata
);

   op_type     op;
   status_type sts;

   feg_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .op        (op)
   );

   feg_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .op        (op),
      .sts       (sts)
   );

endmodule

`default_nettype wire
